// ===== sv/afm_pkg.sv =====
// ----------------------------------------------------------------------------
// afm_pkg
// Shared codes and types of the three-point affine fit and map core.
// ----------------------------------------------------------------------------
package afm_pkg;

	typedef enum logic [1:0] {
		OP_LOAD,
		OP_SOLVE,
		OP_TRANSFORM,
		OP_DEFORM
	} afm_op_t;

	typedef enum logic [1:0] {
		ST_OK,
		ST_SINGULAR,
		ST_SAT
	} afm_status_t;

	typedef enum logic [1:0] {
		K_NOP,
		K_LOAD,
		K_SOLVE,
		K_MAP
	} afm_kind_t;

	// number of mark pairs held
	localparam logic [1:0] MARK_COUNT = 2'd3;

	typedef struct packed {
		afm_kind_t  kind;
		logic       offset;
		logic [1:0] index;
	} afm_cls_t;

endpackage

// ===== sv/afm_front.sv =====
// ----------------------------------------------------------------------------
// afm_front
// Accepts input words, decodes them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module afm_front #(
	parameter int W = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_stall,
	input  logic [1:0]            operation,
	input  logic [1:0]            mark_index,
	input  logic signed [W-1:0]   source_x,
	input  logic signed [W-1:0]   source_y,
	input  logic signed [W-1:0]   dest_x,
	input  logic signed [W-1:0]   dest_y,
	input  logic signed [W-1:0]   point_x,
	input  logic signed [W-1:0]   point_y,
	output logic                  head_valid,
	output afm_pkg::afm_cls_t     head_cls,
	output logic signed [W-1:0]   head_crd [4],
	input  logic                  head_pop
);
	import afm_pkg::*;

	afm_cls_t            cls;
	logic signed [W-1:0] crd [4];
	afm_cls_t            cls_q [2];
	logic signed [W-1:0] crd_q [2][4];
	logic                wr_q;
	logic                rd_q;
	logic [1:0]          cnt_q;
	logic                push;
	logic                pop;

	always_comb begin
		cls.kind   = K_NOP;
		cls.offset = 1'b0;
		cls.index  = mark_index;
		case (afm_op_t'(operation))
			OP_LOAD: begin
				cls.kind = (mark_index < MARK_COUNT) ? K_LOAD : K_NOP;
			end
			OP_SOLVE: begin
				cls.kind = K_SOLVE;
			end
			OP_TRANSFORM: begin
				cls.kind   = K_MAP;
				cls.offset = 1'b1;
			end
			OP_DEFORM: begin
				cls.kind = K_MAP;
			end
			default: begin
				cls.kind = K_NOP;
			end
		endcase
		// loads keep the whole pair, maps only the point
		crd[0] = (cls.kind == K_LOAD) ? source_x : point_x;
		crd[1] = (cls.kind == K_LOAD) ? source_y : point_y;
		crd[2] = dest_x;
		crd[3] = dest_y;
	end

	assign item_stall = (cnt_q == 2'd2);
	assign push       = item_valid && !item_stall;
	assign head_valid = (cnt_q != 2'd0);
	assign pop        = head_pop && head_valid;
	assign head_cls   = cls_q[rd_q];
	assign head_crd   = crd_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				cls_q[wr_q] <= cls;
				crd_q[wr_q] <= crd;
				wr_q        <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

// ===== sv/afm_mul.sv =====
// ----------------------------------------------------------------------------
// afm_mul
// Shared signed multiplier, sixteen bits of the second operand per cycle.
// ----------------------------------------------------------------------------
module afm_mul #(
	parameter int AW_A = 33,
	parameter int BW_B = 33
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic signed [AW_A-1:0]      a,
	input  logic signed [BW_B-1:0]      b,
	output logic                        done,
	output logic signed [AW_A+BW_B-1:0] p
);
	localparam int DG   = 16;
	localparam int NDIG = (BW_B + DG - 1) / DG;
	localparam int NB   = NDIG * DG;
	localparam int PW   = AW_A + BW_B;
	localparam int CNTW = (NDIG > 1) ? $clog2(NDIG) : 1;

	logic [AW_A-1:0]      am_q;
	logic [NB-1:0]        bm_q;
	logic                 neg_q;
	logic [PW-1:0]        acc_q;
	logic [CNTW-1:0]      cnt_q;
	logic                 run_q;
	logic                 fin_q;
	logic                 done_q;
	logic signed [PW-1:0] p_q;
	logic [AW_A+DG-1:0]   pp;
	logic [AW_A-1:0]      a_mag;
	logic [BW_B-1:0]      b_mag;

	assign a_mag = a[AW_A-1] ? AW_A'(-a) : AW_A'(a);
	assign b_mag = b[BW_B-1] ? BW_B'(-b) : BW_B'(b);
	assign pp    = am_q * bm_q[NB-1 -: DG];
	assign done  = done_q;
	assign p     = p_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				am_q  <= a_mag;
				bm_q  <= NB'(b_mag);
				neg_q <= a[AW_A-1] ^ b[BW_B-1];
				acc_q <= '0;
				cnt_q <= '0;
				run_q <= 1'b1;
			end else if (run_q) begin
				// top digit first, so the running sum only shifts by a fixed amount
				acc_q <= (acc_q << DG) + PW'(pp);
				bm_q  <= bm_q << DG;
				cnt_q <= cnt_q + CNTW'(1);
				if (cnt_q == CNTW'(NDIG - 1)) begin
					run_q <= 1'b0;
					fin_q <= 1'b1;
				end
			end else if (fin_q) begin
				fin_q  <= 1'b0;
				p_q    <= neg_q ? -$signed(acc_q) : $signed(acc_q);
				done_q <= 1'b1;
			end
		end
	end

endmodule

// ===== sv/afm_back.sv =====
// ----------------------------------------------------------------------------
// afm_back
// Executes queued words: mark loads, the fit and point mapping.
// ----------------------------------------------------------------------------
module afm_back #(
	parameter int W = 32,
	parameter int F = 28
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  head_valid,
	input  afm_pkg::afm_cls_t     head_cls,
	input  logic signed [W-1:0]   head_crd [4],
	output logic                  head_pop,
	output logic                  result_valid,
	input  logic                  result_stall,
	output logic signed [W-1:0]   out_x,
	output logic signed [W-1:0]   out_y,
	output logic [1:0]            status
);
	import afm_pkg::*;

	localparam int CW   = F + 4;
	localparam int DFW  = W + 1;
	localparam int A    = (DFW > CW) ? DFW : CW;
	localparam int B    = DFW;
	localparam int PW   = A + B;
	localparam int DW   = 2 * W + 5;
	localparam int AW   = (PW + 2 > DW) ? PW + 2 : DW;
	localparam int DCW  = $clog2(CW);

	typedef enum logic [2:0] {
		S_IDLE, S_INIT, S_START, S_MUL, S_FIN, S_DIV, S_DIVEND, S_OUT
	} state_t;

	typedef enum logic [3:0] {
		J_DET, J_NUM0, J_NUM1, J_NUM2, J_NUM3, J_OFF0, J_OFF1, J_MAPX, J_MAPY
	} job_t;

	state_t               state_q;
	job_t                 job_q;
	job_t                 job_nxt;
	logic                 term_q;
	logic signed [AW-1:0] acc_q;
	logic [DW-1:0]        det_q;
	logic                 detneg_q;
	logic [DW-1:0]        rem_q;
	logic [CW-1:0]        quo_q;
	logic [DCW-1:0]       dcnt_q;
	logic                 dneg_q;
	logic                 sat_q;
	logic                 ofs_q;
	logic signed [W-1:0]  src_q [6];
	logic signed [W-1:0]  dst_q [6];
	logic signed [CW-1:0] coef_q [4];
	logic signed [W-1:0]  off_q [2];
	logic signed [W-1:0]  pt_q [2];
	logic signed [W-1:0]  res_x_q;
	logic signed [W-1:0]  res_y_q;
	afm_status_t          res_st_q;
	logic                 rv_q;
	logic signed [W-1:0]  ox_q;
	logic signed [W-1:0]  oy_q;
	afm_status_t          ost_q;

	logic signed [DFW-1:0] sx1, sy1, sx2, sy2, dx1, dy1, dx2, dy2;
	logic signed [A-1:0]   op_a;
	logic signed [B-1:0]   op_b;
	logic                  op_sub;
	logic signed [W-1:0]   base;
	logic                  mul_start;
	logic                  mul_done;
	logic signed [PW-1:0]  mul_p;
	logic signed [AW-1:0]  rsum;
	logic signed [AW-1:0]  rsh;
	logic [AW-W:0]         rtop;
	logic                  fits;
	logic signed [W-1:0]   clampv;
	logic [AW-1:0]         acc_mag;
	logic [DW-1:0]         nmag;
	logic                  big;
	logic                  nneg;
	logic [DW-1:0]         four_d;
	logic                  ge;
	logic [DW-1:0]         rtmp;
	logic [CW:0]           qp1;
	logic [CW-1:0]         qr;
	logic                  povf;
	logic                  novf;
	logic [CW-1:0]         cmag;
	logic signed [CW-1:0]  coefv;
	logic                  rsat;
	logic signed [CW-1:0]  bigv;
	logic [1:0]            cidx;
	logic                  out_load;

	// edge differences from mark zero
	assign sx1 = DFW'(src_q[2]) - DFW'(src_q[0]);
	assign sy1 = DFW'(src_q[3]) - DFW'(src_q[1]);
	assign sx2 = DFW'(src_q[4]) - DFW'(src_q[0]);
	assign sy2 = DFW'(src_q[5]) - DFW'(src_q[1]);
	assign dx1 = DFW'(dst_q[2]) - DFW'(dst_q[0]);
	assign dy1 = DFW'(dst_q[3]) - DFW'(dst_q[1]);
	assign dx2 = DFW'(dst_q[4]) - DFW'(dst_q[0]);
	assign dy2 = DFW'(dst_q[5]) - DFW'(dst_q[1]);

	always_comb begin
		op_a    = '0;
		op_b    = '0;
		op_sub  = 1'b0;
		base    = '0;
		cidx    = 2'd0;
		job_nxt = job_t'(job_q + 4'd1);
		case (job_q)
			J_DET: begin
				op_a   = term_q ? A'(sx2) : A'(sy2);
				op_b   = term_q ? sy1 : sx1;
				op_sub = term_q;
			end
			J_NUM0: begin
				op_a   = term_q ? A'(dx2) : A'(dx1);
				op_b   = term_q ? sy1 : sy2;
				op_sub = term_q;
				cidx   = 2'd0;
			end
			J_NUM1: begin
				op_a   = term_q ? A'(sx2) : A'(sx1);
				op_b   = term_q ? dx1 : dx2;
				op_sub = term_q;
				cidx   = 2'd1;
			end
			J_NUM2: begin
				op_a   = term_q ? A'(dy2) : A'(dy1);
				op_b   = term_q ? sy1 : sy2;
				op_sub = term_q;
				cidx   = 2'd2;
			end
			J_NUM3: begin
				op_a    = term_q ? A'(sx2) : A'(sx1);
				op_b    = term_q ? dy1 : dy2;
				op_sub  = term_q;
				cidx    = 2'd3;
				job_nxt = J_OFF0;
			end
			J_OFF0: begin
				op_a   = term_q ? A'(coef_q[1]) : A'(coef_q[0]);
				op_b   = term_q ? B'(src_q[1]) : B'(src_q[0]);
				op_sub = 1'b1;
				base   = dst_q[0];
			end
			J_OFF1: begin
				op_a   = term_q ? A'(coef_q[3]) : A'(coef_q[2]);
				op_b   = term_q ? B'(src_q[1]) : B'(src_q[0]);
				op_sub = 1'b1;
				base   = dst_q[1];
			end
			J_MAPX: begin
				op_a = term_q ? A'(coef_q[1]) : A'(coef_q[0]);
				op_b = term_q ? B'(pt_q[1]) : B'(pt_q[0]);
				base = ofs_q ? off_q[0] : '0;
			end
			J_MAPY: begin
				op_a = term_q ? A'(coef_q[3]) : A'(coef_q[2]);
				op_b = term_q ? B'(pt_q[1]) : B'(pt_q[0]);
				base = ofs_q ? off_q[1] : '0;
			end
			default: begin
				op_sub = 1'b0;
			end
		endcase
	end

	// round half up to an integer and clamp to the coordinate width
	assign rsum   = acc_q + (AW'(1) <<< (F - 1));
	assign rsh    = rsum >>> F;
	assign rtop   = rsh[AW-1:W-1];
	assign fits   = (&rtop) | ~(|rtop);
	assign clampv = fits ? rsh[W-1:0] :
		(rsh[AW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}});

	// divider setup and one restoring step per cycle against four times det
	assign acc_mag = acc_q[AW-1] ? AW'(-acc_q) : AW'(acc_q);
	assign nmag    = acc_mag[DW-1:0];
	assign nneg    = acc_q[AW-1] ^ detneg_q;
	assign big     = {3'b000, nmag} >= {det_q, 3'b000};
	assign bigv    = nneg ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
	assign four_d  = {det_q[DW-3:0], 2'b00};
	assign ge      = rem_q >= four_d;
	assign rtmp    = ge ? (rem_q - four_d) : rem_q;

	assign qp1   = {1'b0, quo_q} + (CW+1)'(1);
	assign qr    = qp1[CW:1];
	assign povf  = qr[CW-1];
	assign novf  = qr[CW-1] & (|qr[CW-2:0]);
	assign cmag  = dneg_q ? qr : (povf ? {1'b0, {(CW-1){1'b1}}} : qr);
	assign coefv = dneg_q ? -$signed(cmag) : $signed(cmag);
	assign rsat  = dneg_q ? novf : povf;

	assign mul_start = (state_q == S_START);
	assign head_pop  = (state_q == S_IDLE) && head_valid;
	assign out_load  = (state_q == S_OUT) && (!rv_q || !result_stall);

	afm_mul #(
		.AW_A (A),
		.BW_B (B)
	) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (op_a),
		.b      (op_b),
		.done   (mul_done),
		.p      (mul_p)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			job_q   <= J_DET;
			term_q  <= 1'b0;
			rv_q    <= 1'b0;
			for (int i = 0; i < 6; i++) begin
				src_q[i] <= '0;
				dst_q[i] <= '0;
			end
			coef_q[0] <= CW'(1) <<< F;
			coef_q[1] <= '0;
			coef_q[2] <= '0;
			coef_q[3] <= CW'(1) <<< F;
			off_q[0]  <= '0;
			off_q[1]  <= '0;
		end else begin
			if (out_load) begin
				rv_q <= 1'b1;
			end else if (!result_stall) begin
				rv_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (head_valid) begin
						res_x_q  <= '0;
						res_y_q  <= '0;
						res_st_q <= ST_OK;
						sat_q    <= 1'b0;
						case (head_cls.kind)
							K_LOAD: begin
								src_q[{head_cls.index, 1'b0}] <= head_crd[0];
								src_q[{head_cls.index, 1'b1}] <= head_crd[1];
								dst_q[{head_cls.index, 1'b0}] <= head_crd[2];
								dst_q[{head_cls.index, 1'b1}] <= head_crd[3];
								state_q <= S_OUT;
							end
							K_SOLVE: begin
								job_q   <= J_DET;
								state_q <= S_INIT;
							end
							K_MAP: begin
								pt_q[0] <= head_crd[0];
								pt_q[1] <= head_crd[1];
								ofs_q   <= head_cls.offset;
								job_q   <= J_MAPX;
								state_q <= S_INIT;
							end
							default: begin
								state_q <= S_OUT;
							end
						endcase
					end
				end
				S_INIT: begin
					acc_q   <= AW'(base) <<< F;
					term_q  <= 1'b0;
					state_q <= S_START;
				end
				S_START: begin
					state_q <= S_MUL;
				end
				S_MUL: begin
					if (mul_done) begin
						acc_q <= op_sub ? (acc_q - AW'(mul_p)) : (acc_q + AW'(mul_p));
						if (!term_q) begin
							term_q  <= 1'b1;
							state_q <= S_START;
						end else begin
							state_q <= S_FIN;
						end
					end
				end
				S_FIN: begin
					case (job_q)
						J_DET: begin
							if (acc_q == '0) begin
								res_st_q <= ST_SINGULAR;
								state_q  <= S_OUT;
							end else begin
								det_q    <= nmag;
								detneg_q <= acc_q[AW-1];
								job_q    <= J_NUM0;
								state_q  <= S_INIT;
							end
						end
						J_NUM0, J_NUM1, J_NUM2, J_NUM3: begin
							dneg_q <= nneg;
							if (big) begin
								coef_q[cidx] <= bigv;
								sat_q        <= 1'b1;
								job_q        <= job_nxt;
								state_q      <= S_INIT;
							end else begin
								rem_q   <= nmag;
								quo_q   <= '0;
								dcnt_q  <= '0;
								state_q <= S_DIV;
							end
						end
						J_OFF0: begin
							off_q[0] <= clampv;
							sat_q    <= sat_q | !fits;
							job_q    <= J_OFF1;
							state_q  <= S_INIT;
						end
						J_OFF1: begin
							off_q[1] <= clampv;
							res_st_q <= (sat_q || !fits) ? ST_SAT : ST_OK;
							state_q  <= S_OUT;
						end
						J_MAPX: begin
							res_x_q <= clampv;
							sat_q   <= sat_q | !fits;
							job_q   <= J_MAPY;
							state_q <= S_INIT;
						end
						J_MAPY: begin
							res_y_q  <= clampv;
							res_st_q <= (sat_q || !fits) ? ST_SAT : ST_OK;
							state_q  <= S_OUT;
						end
						default: begin
							state_q <= S_OUT;
						end
					endcase
				end
				S_DIV: begin
					rem_q  <= {rtmp[DW-2:0], 1'b0};
					quo_q  <= {quo_q[CW-2:0], ge};
					dcnt_q <= dcnt_q + DCW'(1);
					if (dcnt_q == DCW'(CW - 1)) begin
						state_q <= S_DIVEND;
					end
				end
				S_DIVEND: begin
					coef_q[cidx] <= coefv;
					sat_q        <= sat_q | rsat;
					job_q        <= job_nxt;
					state_q      <= S_INIT;
				end
				S_OUT: begin
					if (out_load) begin
						ox_q    <= res_x_q;
						oy_q    <= res_y_q;
						ost_q   <= res_st_q;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign result_valid = rv_q;
	assign out_x        = ox_q;
	assign out_y        = oy_q;
	assign status       = ost_q;

endmodule

// ===== sv/three_point_affine_fit_and_map_core.sv =====
// ----------------------------------------------------------------------------
// three_point_affine_fit_and_map_core
// Fits an affine map to three mark pairs and maps points through it.
// ----------------------------------------------------------------------------
// Input words arrive on item_valid/item_stall, one operation each: load a mark
// pair, solve the fit, transform a point (matrix and offset) or deform it
// (matrix only). Every word gives exactly one result word on
// result_valid/result_stall carrying out_x, out_y and status.
// A two-entry queue decouples the decoder from the executing sequencer, so
// input words keep flowing while a result waits in the output register.
// Work per word, from leaving the queue to the result register: a load is
// written directly, a transform or deform takes four products on the
// shared multiplier at 16 operand bits per cycle, and a solve takes ten
// products, four quotients at one bit per cycle over up to COEF_FRAC_BITS+4
// steps each, and four more products for the offsets.
// Words are taken one at a time by the sequencer.
// Reset clears the marks and offsets and loads the identity matrix.
// While result_stall is high the result holds, the sequencer waits with the
// next result, and the queue fills and then raises item_stall.
// ----------------------------------------------------------------------------
module three_point_affine_fit_and_map_core #(
	parameter int COORD_WIDTH    = 32,
	parameter int COEF_FRAC_BITS = 28
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_stall,
	input  logic [1:0]                    operation,
	input  logic [1:0]                    mark_index,
	input  logic signed [COORD_WIDTH-1:0] source_x,
	input  logic signed [COORD_WIDTH-1:0] source_y,
	input  logic signed [COORD_WIDTH-1:0] dest_x,
	input  logic signed [COORD_WIDTH-1:0] dest_y,
	input  logic signed [COORD_WIDTH-1:0] point_x,
	input  logic signed [COORD_WIDTH-1:0] point_y,
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic signed [COORD_WIDTH-1:0] out_x,
	output logic signed [COORD_WIDTH-1:0] out_y,
	output logic [1:0]                    status
);
	import afm_pkg::*;

	logic                          head_valid;
	afm_cls_t                      head_cls;
	logic signed [COORD_WIDTH-1:0] head_crd [4];
	logic                          head_pop;

	afm_front #(
		.W (COORD_WIDTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.operation  (operation),
		.mark_index (mark_index),
		.source_x   (source_x),
		.source_y   (source_y),
		.dest_x     (dest_x),
		.dest_y     (dest_y),
		.point_x    (point_x),
		.point_y    (point_y),
		.head_valid (head_valid),
		.head_cls   (head_cls),
		.head_crd   (head_crd),
		.head_pop   (head_pop)
	);

	afm_back #(
		.W (COORD_WIDTH),
		.F (COEF_FRAC_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head_cls     (head_cls),
		.head_crd     (head_crd),
		.head_pop     (head_pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.out_x        (out_x),
		.out_y        (out_y),
		.status       (status)
	);

endmodule

// ===== sv/afm_checker.sv =====
// ----------------------------------------------------------------------------
// afm_checker
// Port-level checks of the affine fit and map core.
// ----------------------------------------------------------------------------
module afm_checker #(
	parameter int COORD_WIDTH = 32
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   item_valid,
	input logic                   item_stall,
	input logic                   result_valid,
	input logic                   result_stall,
	input logic [COORD_WIDTH-1:0] out_x,
	input logic [COORD_WIDTH-1:0] out_y,
	input logic [1:0]             status
);
	import afm_pkg::*;

	logic [2:0] pend_q;
	logic       in_take;
	logic       out_take;

	assign in_take  = item_valid && !item_stall;
	assign out_take = result_valid && !result_stall;

	// words taken in but not yet answered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 3'd0;
		end else begin
			pend_q <= pend_q + {2'b00, in_take} - {2'b00, out_take};
		end
	end

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> pend_q != 3'd0)
		else $error("result word without a pending input word");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (status == ST_OK || status == ST_SINGULAR || status == ST_SAT))
		else $error("undefined status code");

	a_singular_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && status == ST_SINGULAR |-> out_x == '0 && out_y == '0)
		else $error("rejected fit returned a nonzero point");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(out_x)
			&& $stable(out_y) && $stable(status))
		else $error("stalled result word changed");

endmodule

bind three_point_affine_fit_and_map_core afm_checker #(
	.COORD_WIDTH (COORD_WIDTH)
) u_afm_checker (.*);
